[sv/wpr_pkg.sv]
`timescale 1ns / 1ps

package wpr_pkg;

  localparam int SAMPLE_W = 16;
  localparam int MAG_W    = 15;
  localparam int INDEX_W  = 16;
  localparam int FRAME_W  = 32;
  localparam int BUCKET_W = 16;
  localparam int CHAN_W   = 4;
  localparam int SQ_W     = 31;
  localparam int SUM_W    = 64;
  localparam int COUNT_W  = 40;
  localparam int PADDR_W  = 4;
  localparam int PDATA_W  = 32;

  localparam logic [FRAME_W-1:0]  FRAMES_RST   = FRAME_W'(1);
  localparam logic [CHAN_W-1:0]   CHANNELS_RST = CHAN_W'(1);
  localparam logic [BUCKET_W-1:0] BUCKETS_RST  = BUCKET_W'(1000);
  localparam logic [MAG_W-1:0]    RMS_MAX      = {MAG_W{1'b1}};

  typedef enum logic [1:0] {
    REG_FRAMES   = 2'd0,
    REG_CHANNELS = 2'd1,
    REG_BUCKETS  = 2'd2
  } reg_idx_t;

  // Register values; frame and bucket counts after the zero and range fixes.
  typedef struct packed {
    logic [FRAME_W-1:0]  eff_frames;
    logic [BUCKET_W-1:0] eff_buckets;
    logic [CHAN_W-1:0]   channels;
  } wpr_cfg_t;

  typedef struct packed {
    logic accept;
    logic square;
    logic accum;
    logic div_start;
    logic div_cfg;
    logic div_step;
    logic sqrt_start;
    logic sqrt_step;
    logic emit;
    logic cfg_load;
  } wpr_cmd_t;

  typedef struct packed {
    logic close;
    logic cnt_zero;
    logic div_last;
    logic sqrt_last;
    logic out_free;
  } wpr_sts_t;

endpackage

[sv/wpr_ifs.sv]
`timescale 1ns / 1ps

interface wpr_in_if;
  import wpr_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       sample_bad;

  modport source (output valid, output sample, output sample_bad, input ready);
  modport sink   (input valid, input sample, input sample_bad, output ready);
endinterface

interface wpr_out_if;
  import wpr_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [INDEX_W-1:0]         bucket_index;
  logic signed [SAMPLE_W-1:0] peak_min;
  logic [MAG_W-1:0]           peak_max;
  logic [MAG_W-1:0]           rms_level;
  logic                       last_bucket;

  modport source (output valid, output bucket_index, output peak_min, output peak_max,
                  output rms_level, output last_bucket, input ready);
  modport sink   (input valid, input bucket_index, input peak_min, input peak_max,
                  input rms_level, input last_bucket, output ready);
endinterface

[sv/waveform_peak_rms_buckets.sv]
`timescale 1ns / 1ps

// Channel  | Kind       | Payload
// ---------+------------+------------------------------------------------------
// in_ch    | sink       | sample (s16, Q1.15), sample_bad
// out_ch   | source     | bucket_index, peak_min, peak_max, rms_level, last_bucket
// cfg_*    | APB slave  | 0x0 frame_total, 0x4 channel_count, 0x8 bucket_count
//
// A sample that does not close a bucket is accepted, squared and accumulated.
// A sample that closes a bucket with counted samples then runs a 64-step mean
// divide and a 32-step square root, in sequence on the shared datapath.
// A bucket with no counted samples skips both. A register write recomputes the
// bucket step with the same divider; no sample is taken until the new step is loaded.
// Reset loads frame_total 1, channel_count 1, bucket_count 1000.
// One finished result can wait in the output register while the next sample is
// taken; a further bucket close holds until that register has been read.

module waveform_peak_rms_buckets #(
  parameter int MAX_CHANNELS = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  wpr_in_if.sink                      in_ch,
  wpr_out_if.source                   out_ch,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [wpr_pkg::PADDR_W-1:0] cfg_paddr,
  input  logic [wpr_pkg::PDATA_W-1:0] cfg_pwdata,
  output logic [wpr_pkg::PDATA_W-1:0] cfg_prdata,
  output logic                        cfg_pready
);
  import wpr_pkg::*;

  wpr_cfg_t cfg;
  wpr_cmd_t cmd;
  wpr_sts_t sts;
  logic     cfg_wr;
  logic     in_ready;

  assign cfg_pready = 1'b1;
  assign in_ch.ready = in_ready;

  wpr_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_wr      (cfg_wr),
    .cfg         (cfg)
  );

  wpr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .cfg_wr   (cfg_wr),
    .sts      (sts),
    .cmd      (cmd)
  );

  wpr_dp #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .cfg              (cfg),
    .in_sample        (in_ch.sample),
    .in_sample_bad    (in_ch.sample_bad),
    .out_ready        (out_ch.ready),
    .out_valid        (out_ch.valid),
    .out_bucket_index (out_ch.bucket_index),
    .out_peak_min     (out_ch.peak_min),
    .out_peak_max     (out_ch.peak_max),
    .out_rms_level    (out_ch.rms_level),
    .out_last_bucket  (out_ch.last_bucket)
  );

endmodule

[sv/wpr_cfg.sv]
`timescale 1ns / 1ps

module wpr_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [wpr_pkg::PADDR_W-1:0]  cfg_paddr,
  input  logic [wpr_pkg::PDATA_W-1:0]  cfg_pwdata,
  output logic [wpr_pkg::PDATA_W-1:0]  cfg_prdata,
  output logic                         cfg_wr,
  output wpr_pkg::wpr_cfg_t            cfg
);
  import wpr_pkg::*;

  logic [FRAME_W-1:0]  frames_r;
  logic [CHAN_W-1:0]   channels_r;
  logic [BUCKET_W-1:0] buckets_r;
  logic                wr_en;
  logic                idx_known;
  logic [FRAME_W-1:0]  frames_eff;
  logic [BUCKET_W-1:0] buckets_nz;

  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_FRAMES: begin
        idx_known  = 1'b1;
        cfg_prdata = frames_r;
      end
      REG_CHANNELS: begin
        idx_known  = 1'b1;
        cfg_prdata = PDATA_W'(channels_r);
      end
      REG_BUCKETS: begin
        idx_known  = 1'b1;
        cfg_prdata = PDATA_W'(buckets_r);
      end
      default: begin
        idx_known  = 1'b0;
        cfg_prdata = '0;
      end
    endcase
  end

  // Any write to a defined register restarts the stream.
  assign cfg_wr = wr_en && idx_known;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_r   <= FRAMES_RST;
      channels_r <= CHANNELS_RST;
      buckets_r  <= BUCKETS_RST;
    end else if (wr_en) begin
      unique case (cfg_paddr[3:2])
        REG_FRAMES:   frames_r   <= cfg_pwdata[FRAME_W-1:0];
        REG_CHANNELS: channels_r <= cfg_pwdata[CHAN_W-1:0];
        REG_BUCKETS:  buckets_r  <= cfg_pwdata[BUCKET_W-1:0];
        default: ;
      endcase
    end
  end

  // The bucket count is clamped to the frame count so no bucket is empty of frames.
  assign frames_eff = (frames_r == '0) ? FRAME_W'(1) : frames_r;
  assign buckets_nz = (buckets_r == '0) ? BUCKET_W'(1) : buckets_r;

  always_comb begin
    cfg.eff_frames  = frames_eff;
    cfg.eff_buckets = (FRAME_W'(buckets_nz) > frames_eff) ? frames_eff[BUCKET_W-1:0]
                                                          : buckets_nz;
    cfg.channels    = channels_r;
  end

endmodule

[sv/wpr_ctrl.sv]
`timescale 1ns / 1ps

module wpr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              cfg_wr,
  input  wpr_pkg::wpr_sts_t sts,
  output wpr_pkg::wpr_cmd_t cmd
);
  import wpr_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQUARE,
    S_ACCUM,
    S_DIV_LOAD,
    S_DIV,
    S_SQRT_LOAD,
    S_SQRT,
    S_EMIT,
    S_CFG_START,
    S_CFG_DIV,
    S_CFG_LOAD
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = rst_n && (state_r == S_IDLE) && !cfg_wr;
    if (cfg_wr) begin
      // A register write abandons whatever runs. The divider is loaded in S_CFG_START,
      // once the new register value is in place.
      state_nxt = S_CFG_START;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            cmd.accept = 1'b1;
            state_nxt  = S_SQUARE;
          end
        end
        S_SQUARE: begin
          cmd.square = 1'b1;
          state_nxt  = S_ACCUM;
        end
        S_ACCUM: begin
          cmd.accum = 1'b1;
          priority if (!sts.close) state_nxt = S_IDLE;
          else if (sts.cnt_zero)   state_nxt = S_EMIT;
          else                     state_nxt = S_DIV_LOAD;
        end
        S_DIV_LOAD: begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end
        S_DIV: begin
          cmd.div_step = 1'b1;
          if (sts.div_last) state_nxt = S_SQRT_LOAD;
        end
        S_SQRT_LOAD: begin
          cmd.sqrt_start = 1'b1;
          state_nxt      = S_SQRT;
        end
        S_SQRT: begin
          cmd.sqrt_step = 1'b1;
          if (sts.sqrt_last) state_nxt = S_EMIT;
        end
        S_EMIT: begin
          if (sts.out_free) begin
            cmd.emit  = 1'b1;
            state_nxt = S_IDLE;
          end
        end
        S_CFG_START: begin
          cmd.div_start = 1'b1;
          cmd.div_cfg   = 1'b1;
          state_nxt     = S_CFG_DIV;
        end
        S_CFG_DIV: begin
          cmd.div_step = 1'b1;
          if (sts.div_last) state_nxt = S_CFG_LOAD;
        end
        S_CFG_LOAD: begin
          cmd.cfg_load = 1'b1;
          state_nxt    = S_IDLE;
        end
        default: state_nxt = S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_accum_after_square: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ACCUM |-> $past(state_r) == S_SQUARE)
    else $error("accumulate step not preceded by square step");

  a_sqrt_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SQRT |-> ($past(state_r) == S_SQRT_LOAD || $past(state_r) == S_SQRT))
    else $error("square root running without a finished divide");

  a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> state_r == S_IDLE)
    else $error("input ready outside the idle state");

endmodule

[sv/wpr_dp.sv]
`timescale 1ns / 1ps

module wpr_dp #(
  parameter int MAX_CHANNELS = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  wpr_pkg::wpr_cmd_t                  cmd,
  output wpr_pkg::wpr_sts_t                  sts,
  input  wpr_pkg::wpr_cfg_t                  cfg,
  input  logic signed [wpr_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                               in_sample_bad,
  input  logic                               out_ready,
  output logic                               out_valid,
  output logic [wpr_pkg::INDEX_W-1:0]        out_bucket_index,
  output logic signed [wpr_pkg::SAMPLE_W-1:0] out_peak_min,
  output logic [wpr_pkg::MAG_W-1:0]          out_peak_max,
  output logic [wpr_pkg::MAG_W-1:0]          out_rms_level,
  output logic                               out_last_bucket
);
  import wpr_pkg::*;

  localparam int CHW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS + 1) : 1;
  localparam int CEW = (CHW > CHAN_W) ? CHW : CHAN_W;
  localparam int DVD_W = SUM_W;
  localparam int DCW = $clog2(DVD_W);

  // Sample pipeline.
  logic signed [SAMPLE_W-1:0]   smp_r;
  logic                         bad_r;
  logic [SQ_W-1:0]              sq_r;
  logic                         sq_ok_r;
  logic signed [2*SAMPLE_W-1:0] prod;

  // Stream position and bucket accumulators.
  logic [CHW-1:0]             ch_r;
  logic [FRAME_W-1:0]         frame_r;
  logic [BUCKET_W-1:0]        bucket_r;
  logic [FRAME_W-1:0]         end_r;
  logic [BUCKET_W-1:0]        rem_r;
  logic [FRAME_W-1:0]         step_q_r;
  logic [BUCKET_W-1:0]        step_r_r;
  logic signed [SAMPLE_W-1:0] min_r;
  logic signed [SAMPLE_W-1:0] max_r;
  logic [SUM_W-1:0]           sum_r;
  logic [COUNT_W-1:0]         cnt_r;
  logic                       close_r;

  // Shared divider and square root.
  logic [DVD_W-1:0]   dvd_r;
  logic [COUNT_W-1:0] dvs_r;
  logic [COUNT_W-1:0] drem_r;
  logic [DCW-1:0]     dk_r;
  logic [SUM_W-1:0]   x_r;
  logic [SUM_W-1:0]   res_r;
  logic [4:0]         sk_r;
  logic               out_valid_r;

  logic [CEW-1:0]     ch_ext;
  logic [CEW-1:0]     eff_ch;
  logic [CEW-1:0]     ch_inc;
  logic [FRAME_W:0]   frame_inc;
  logic [BUCKET_W:0]  bucket_inc;
  logic               last;
  logic               restart;
  logic [BUCKET_W:0]  rem_sum;
  logic               rem_wrap;
  logic [SUM_W:0]     sum_ext;
  logic [COUNT_W:0]   drem_sh;
  logic [COUNT_W:0]   drem_diff;
  logic               dge;
  logic [SUM_W-1:0]   bitv;
  logic [SUM_W-1:0]   sq_try;
  logic               sge;
  logic [MAG_W-1:0]   rms_sat;

  assign prod = smp_r * smp_r;

  assign ch_ext = CEW'(cfg.channels);
  always_comb begin
    priority if (ch_ext == '0)                 eff_ch = CEW'(1);
    else if (ch_ext > CEW'(MAX_CHANNELS))      eff_ch = CEW'(MAX_CHANNELS);
    else                                       eff_ch = ch_ext;
  end
  assign ch_inc    = CEW'(ch_r) + CEW'(1);
  assign frame_inc = {1'b0, frame_r} + (FRAME_W + 1)'(1);

  assign bucket_inc = {1'b0, bucket_r} + (BUCKET_W + 1)'(1);
  assign last       = bucket_inc >= {1'b0, cfg.eff_buckets};
  assign restart    = last || (frame_r >= cfg.eff_frames);

  // Next boundary: add the step remainder and carry one frame when it wraps.
  assign rem_sum  = {1'b0, rem_r} + {1'b0, step_r_r};
  assign rem_wrap = rem_sum >= {1'b0, cfg.eff_buckets};

  assign sum_ext = {1'b0, sum_r} + (SUM_W + 1)'(sq_r);

  assign drem_sh   = {drem_r, dvd_r[DVD_W-1]};
  assign drem_diff = drem_sh - {1'b0, dvs_r};
  assign dge       = drem_sh >= {1'b0, dvs_r};

  assign bitv    = SUM_W'(1) << {sk_r, 1'b0};
  assign sq_try  = res_r + bitv;
  assign sge     = x_r >= sq_try;
  assign rms_sat = (res_r > SUM_W'(RMS_MAX)) ? RMS_MAX : res_r[MAG_W-1:0];

  always_comb begin
    sts.close     = close_r;
    sts.cnt_zero  = (cnt_r == '0);
    sts.div_last  = (dk_r == '1);
    sts.sqrt_last = (sk_r == '0);
    sts.out_free  = !out_valid_r || out_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_r     <= '0;
      frame_r  <= '0;
      bucket_r <= '0;
      end_r    <= FRAME_W'(1);
      rem_r    <= '0;
      step_q_r <= FRAME_W'(1);
      step_r_r <= '0;
      min_r    <= '0;
      max_r    <= '0;
      sum_r    <= '0;
      cnt_r    <= '0;
      close_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && !cmd.emit) out_valid_r <= 1'b0;

      if (cmd.square) begin
        if (!bad_r) begin
          if (smp_r < min_r) min_r <= smp_r;
          if (smp_r > max_r) max_r <= smp_r;
          if (cnt_r != '1) cnt_r <= cnt_r + COUNT_W'(1);
        end
        if (ch_inc < eff_ch) begin
          ch_r    <= ch_inc[CHW-1:0];
          close_r <= 1'b0;
        end else begin
          ch_r    <= '0;
          frame_r <= frame_inc[FRAME_W-1:0];
          close_r <= frame_inc >= {1'b0, end_r};
        end
      end

      if (cmd.accum && sq_ok_r) begin
        sum_r <= sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
      end

      if (cmd.emit) begin
        out_valid_r <= 1'b1;
        close_r     <= 1'b0;
        min_r       <= '0;
        max_r       <= '0;
        sum_r       <= '0;
        cnt_r       <= '0;
        if (restart) begin
          ch_r     <= '0;
          frame_r  <= '0;
          bucket_r <= '0;
          end_r    <= step_q_r;
          rem_r    <= step_r_r;
        end else begin
          bucket_r <= bucket_inc[BUCKET_W-1:0];
          if (rem_wrap) begin
            rem_r <= BUCKET_W'(rem_sum - {1'b0, cfg.eff_buckets});
            end_r <= end_r + step_q_r + FRAME_W'(1);
          end else begin
            rem_r <= rem_sum[BUCKET_W-1:0];
            end_r <= end_r + step_q_r;
          end
        end
      end

      if (cmd.cfg_load) begin
        step_q_r <= dvd_r[FRAME_W-1:0];
        step_r_r <= drem_r[BUCKET_W-1:0];
        end_r    <= dvd_r[FRAME_W-1:0];
        rem_r    <= drem_r[BUCKET_W-1:0];
        ch_r     <= '0;
        frame_r  <= '0;
        bucket_r <= '0;
        close_r  <= 1'b0;
        min_r    <= '0;
        max_r    <= '0;
        sum_r    <= '0;
        cnt_r    <= '0;
      end
    end
  end

  // Restoring divider, one quotient bit per cycle; the quotient shifts into dvd_r.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dk_r <= '0;
      sk_r <= '0;
    end else begin
      if (cmd.div_start) begin
        dk_r <= '0;
      end else if (cmd.div_step) begin
        dk_r <= dk_r + DCW'(1);
      end
      if (cmd.sqrt_start) begin
        sk_r <= '1;
      end else if (cmd.sqrt_step) begin
        sk_r <= sk_r - 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      smp_r <= in_sample;
      bad_r <= in_sample_bad;
    end
    if (cmd.square) begin
      sq_r    <= prod[SQ_W-1:0];
      sq_ok_r <= !bad_r;
    end

    if (cmd.div_start) begin
      drem_r <= '0;
      if (cmd.div_cfg) begin
        dvd_r <= DVD_W'(cfg.eff_frames);
        dvs_r <= COUNT_W'(cfg.eff_buckets);
      end else begin
        dvd_r <= sum_r;
        dvs_r <= cnt_r;
      end
    end else if (cmd.div_step) begin
      drem_r <= dge ? drem_diff[COUNT_W-1:0] : drem_sh[COUNT_W-1:0];
      dvd_r  <= {dvd_r[DVD_W-2:0], dge};
    end

    // Digit-by-digit square root of the mean, two radicand bits per cycle.
    if (cmd.sqrt_start) begin
      x_r   <= dvd_r;
      res_r <= '0;
    end else if (cmd.sqrt_step) begin
      if (sge) begin
        x_r   <= x_r - sq_try;
        res_r <= (res_r >> 1) + bitv;
      end else begin
        res_r <= res_r >> 1;
      end
    end

    if (cmd.emit) begin
      out_bucket_index <= bucket_r;
      out_peak_min     <= min_r;
      out_peak_max     <= max_r[MAG_W-1:0];
      out_rms_level    <= (cnt_r == '0) ? '0 : rms_sat;
      out_last_bucket  <= last;
    end
  end

  assign out_valid = out_valid_r;

  a_frame_in_bucket: assert property (@(posedge clk) disable iff (!rst_n)
    frame_r <= end_r)
    else $error("frame position ran past the bucket end");

  a_empty_bucket_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && cnt_r == '0) |-> (sum_r == '0 && min_r == '0 && max_r == '0))
    else $error("empty bucket carries accumulated data");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(out_bucket_index)
                                     && $stable(out_rms_level)))
    else $error("result beat changed while stalled");

endmodule
